/* hw/rtl/ostb_pkg.sv */
`timescale 1ns / 1ps

package ostb_pkg;

  // Operation codes carried on in_tuser
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_ARM   = 3'd1,
    OP_QUERY = 3'd2,
    OP_KILL  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_READ  = 3'd5
  } ostb_op_t;

  // Query answers
  typedef enum logic [1:0] {
    TS_IDLE    = 2'd0,
    TS_RUNNING = 2'd1,
    TS_EXPIRED = 2'd2
  } ostb_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_QRY,
    ST_RD,
    ST_DONE
  } ostb_state_t;

  localparam logic [31:0] DOWN_IDLE  = 32'hFFFF_FFFF;
  localparam logic [31:0] DOWN_MAXARM = 32'hFFFF_FFFE;
  localparam logic [15:0] UP_SAT     = 16'hFFFF;

endpackage

/* hw/rtl/ostb_store.sv */
`timescale 1ns / 1ps

// Single-port-write, single-port-read memory with a registered read.
// Entries never written since reset read back as InitVal.
module ostb_store #(
  parameter int          Depth   = 32,
  parameter int          Width   = 32,
  parameter logic [31:0] InitVal = 32'hFFFF_FFFF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                     rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_r;
  logic [Width-1:0] data_r;
  logic             hit_r;

  // Write the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Register the read
  always_ff @(posedge clk) begin
    if (re) begin
      data_r <= mem[raddr];
      hit_r  <= vld_r[raddr];
    end
  end

  // Substitute reset value for untouched entries
  assign rdata = hit_r ? data_r : InitVal[Width-1:0];

endmodule

/* hw/rtl/one_shot_timer_bank.sv */
`timescale 1ns / 1ps

// Channel | Direction | Ports                        | Contents
// in      | slave     | in_tvalid/tready/tdata/tuser | tdata: slot, delay_ticks; tuser: op
// out     | master    | out_tvalid/tready/tdata      | tdata: timer_status, elapsed_count
//
// One operation at a time; every transaction in gives one transaction out.
// Tick walks both timer memories in parallel through their single read and write
// ports. Query and read of a valid slot add one memory read state (ST_QRY, ST_RD);
// all other operations but tick go straight to ST_DONE.
// Synchronous active-low reset marks every timer untouched, so it reads idle
// or saturated; no clearing pass is needed. While the output is stalled one
// more operation is accepted and runs; its result waits in ST_DONE and no
// further transaction is accepted until the output register frees.
module one_shot_timer_bank
  import ostb_pkg::*;
#(
  parameter int NUM_DOWN_TIMERS = 32,
  parameter int NUM_UP_TIMERS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [4:0] slot, [36:5] delay_ticks, [39:37] zero
  input  logic [2:0]  in_tuser,   // [2:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] timer_status, [17:2] elapsed_count, [23:18] zero
);

  localparam int DA      = (NUM_DOWN_TIMERS > 1) ? $clog2(NUM_DOWN_TIMERS) : 1;
  localparam int UA      = (NUM_UP_TIMERS > 1) ? $clog2(NUM_UP_TIMERS) : 1;
  localparam int WalkLen = (NUM_DOWN_TIMERS > NUM_UP_TIMERS) ? NUM_DOWN_TIMERS
                                                             : NUM_UP_TIMERS;
  localparam int IW      = (WalkLen > 1) ? $clog2(WalkLen) : 1;

  localparam logic [5:0]    DnLim   = NUM_DOWN_TIMERS[5:0];
  localparam logic [5:0]    UpLim   = NUM_UP_TIMERS[5:0];
  localparam logic [IW:0]   DnCnt   = NUM_DOWN_TIMERS[IW:0];
  localparam logic [IW:0]   UpCnt   = NUM_UP_TIMERS[IW:0];
  localparam logic [IW-1:0] WalkEnd = IW'(WalkLen - 1);

  // Unpack input
  logic [4:0]  in_slot;
  logic [31:0] in_delay;
  ostb_op_t    in_op;
  logic        in_acc;
  logic        in_dn_ok;
  logic        in_up_ok;

  assign in_slot  = in_tdata[4:0];
  assign in_delay = in_tdata[36:5];
  assign in_op    = ostb_op_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;
  assign in_dn_ok = {1'b0, in_slot} < DnLim;
  assign in_up_ok = {1'b0, in_slot} < UpLim;

  // Sequencer state
  ostb_state_t    state_r, state_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [4:0]     slot_r, slot_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [15:0]    res_elapsed_r, res_elapsed_nxt;
  logic           dn_pend_r, dn_pend_nxt;
  logic [DA-1:0]  dn_pa_r, dn_pa_nxt;
  logic           up_pend_r, up_pend_nxt;
  logic [UA-1:0]  up_pa_r, up_pa_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  logic [23:0]    out_tdata_r, out_tdata_nxt;

  // Memory ports
  logic           dn_we, dn_re, up_we, up_re;
  logic [DA-1:0]  dn_waddr, dn_raddr;
  logic [UA-1:0]  up_waddr, up_raddr;
  logic [31:0]    dn_wdata, dn_rdata;
  logic [15:0]    up_wdata, up_rdata;
  logic           walk_dn, walk_up;

  ostb_store #(
    .Depth  (NUM_DOWN_TIMERS),
    .Width  (32),
    .InitVal(DOWN_IDLE)
  ) u_down (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (dn_we),
    .waddr(dn_waddr),
    .wdata(dn_wdata),
    .re   (dn_re),
    .raddr(dn_raddr),
    .rdata(dn_rdata)
  );

  ostb_store #(
    .Depth  (NUM_UP_TIMERS),
    .Width  (16),
    .InitVal({16'h0000, UP_SAT})
  ) u_up (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (up_we),
    .waddr(up_waddr),
    .wdata(up_wdata),
    .re   (up_re),
    .raddr(up_raddr),
    .rdata(up_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign walk_dn = ({1'b0, idx_r} < DnCnt);
  assign walk_up = ({1'b0, idx_r} < UpCnt);

  // Hold control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dn_pend_r    <= 1'b0;
      up_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      dn_pend_r    <= dn_pend_nxt;
      up_pend_r    <= up_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r        <= slot_nxt;
    res_status_r  <= res_status_nxt;
    res_elapsed_r <= res_elapsed_nxt;
    dn_pa_r       <= dn_pa_nxt;
    up_pa_r       <= up_pa_nxt;
    out_tdata_r   <= out_tdata_nxt;
  end

  // Next state, memory accesses and result
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    slot_nxt        = slot_r;
    res_status_nxt  = res_status_r;
    res_elapsed_nxt = res_elapsed_r;
    dn_pend_nxt     = 1'b0;
    dn_pa_nxt       = dn_pa_r;
    up_pend_nxt     = 1'b0;
    up_pa_nxt       = up_pa_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_tdata_nxt   = out_tdata_r;

    dn_we    = 1'b0;
    dn_waddr = slot_r[DA-1:0];
    dn_wdata = DOWN_IDLE;
    dn_re    = 1'b0;
    dn_raddr = in_slot[DA-1:0];
    up_we    = 1'b0;
    up_waddr = in_slot[UA-1:0];
    up_wdata = 16'h0000;
    up_re    = 1'b0;
    up_raddr = in_slot[UA-1:0];

    // Drop the result once taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // Write back ticked entries from the previous read
    if (dn_pend_r && dn_rdata != DOWN_IDLE && dn_rdata != 32'd0) begin
      dn_we    = 1'b1;
      dn_waddr = dn_pa_r;
      dn_wdata = dn_rdata - 32'd1;
    end
    if (up_pend_r && up_rdata != UP_SAT) begin
      up_we    = 1'b1;
      up_waddr = up_pa_r;
      up_wdata = up_rdata + 16'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          slot_nxt        = in_slot;
          res_status_nxt  = TS_IDLE;
          res_elapsed_nxt = 16'd0;
          idx_nxt         = '0;
          state_nxt       = ST_DONE;
          case (in_op)
            OP_TICK: begin
              state_nxt = ST_WALK;
            end
            OP_ARM: begin
              if (in_dn_ok) begin
                dn_we    = 1'b1;
                dn_waddr = in_slot[DA-1:0];
                dn_wdata = (in_delay == DOWN_IDLE) ? DOWN_MAXARM : in_delay;
              end
            end
            OP_QUERY: begin
              if (in_dn_ok) begin
                dn_re     = 1'b1;
                state_nxt = ST_QRY;
              end
            end
            OP_KILL: begin
              if (in_dn_ok) begin
                dn_we    = 1'b1;
                dn_waddr = in_slot[DA-1:0];
                dn_wdata = DOWN_IDLE;
              end
            end
            OP_CLEAR: begin
              if (in_up_ok) begin
                up_we    = 1'b1;
                up_waddr = in_slot[UA-1:0];
                up_wdata = 16'd0;
              end
            end
            OP_READ: begin
              if (in_up_ok) begin
                up_re     = 1'b1;
                state_nxt = ST_RD;
              end else begin
                res_elapsed_nxt = UP_SAT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Issue one read per cycle to each memory still in range; write back uses the registered read
      ST_WALK: begin
        dn_re       = walk_dn;
        dn_raddr    = idx_r[DA-1:0];
        up_re       = walk_up;
        up_raddr    = idx_r[UA-1:0];
        dn_pend_nxt = walk_dn;
        dn_pa_nxt   = idx_r[DA-1:0];
        up_pend_nxt = walk_up;
        up_pa_nxt   = idx_r[UA-1:0];
        if (idx_r == WalkEnd) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end

      // Classify the timer; an expired one returns to idle
      ST_QRY: begin
        if (dn_rdata == DOWN_IDLE) begin
          res_status_nxt = TS_IDLE;
        end else if (dn_rdata != 32'd0) begin
          res_status_nxt = TS_RUNNING;
        end else begin
          res_status_nxt = TS_EXPIRED;
          dn_we          = 1'b1;
          dn_waddr       = slot_r[DA-1:0];
          dn_wdata       = DOWN_IDLE;
        end
        state_nxt = ST_DONE;
      end

      ST_RD: begin
        res_elapsed_nxt = up_rdata;
        state_nxt       = ST_DONE;
      end

      // Present the result when the output register is free
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'd0, res_elapsed_r, res_status_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
